// ===== sv/tvr_pkg.sv =====
package tvr_pkg;

    // defaults for the top-level parameters
    localparam int DEF_MAX_TREND_WINDOW     = 256;
    localparam int DEF_MAX_RANGE_WINDOW     = 64;
    localparam int DEF_MAX_RANGE_AVG_WINDOW = 256;
    localparam int DEF_PRICE_BITS           = 32;
    localparam int QUEUE_DEPTH              = 2;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam logic [CFG_IDX_W-1:0] REG_TREND_WINDOW     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_WINDOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RANGE_AVG_WINDOW = 2'd2;

    localparam int RST_TREND_WINDOW     = 50;
    localparam int RST_RANGE_WINDOW     = 14;
    localparam int RST_RANGE_AVG_WINDOW = 50;

    // field widths fixed by the interface
    localparam int FIELD_W   = 32;
    localparam int REGIME_W  = 3;
    localparam int BP_OUT_W  = 20;
    localparam int CONF_W    = 7;

    // arithmetic constants
    localparam int ATR_FRAC      = 16;
    localparam int WARMUP_EXTRA  = 5;
    localparam int BP_SCALE_W    = 14;
    localparam logic [BP_SCALE_W-1:0] BP_SCALE = 14'd10000;
    localparam logic [BP_OUT_W-1:0]   BP_MAX   = 20'hFFFFF;

    // regime codes
    localparam logic [REGIME_W-1:0] REGIME_NEUTRAL     = 3'd0;
    localparam logic [REGIME_W-1:0] REGIME_BULL_QUIET  = 3'd1;
    localparam logic [REGIME_W-1:0] REGIME_BULL_VOLAT  = 3'd2;
    localparam logic [REGIME_W-1:0] REGIME_BEAR_QUIET  = 3'd3;
    localparam logic [REGIME_W-1:0] REGIME_BEAR_VOLAT  = 3'd4;

    // confidence values
    localparam logic [CONF_W-1:0] CONF_NONE     = 7'd0;
    localparam logic [CONF_W-1:0] CONF_QUIET    = 7'd85;
    localparam logic [CONF_W-1:0] CONF_VOLATILE = 7'd80;

endpackage

// ===== sv/trend_volatility_regime_classifier.sv =====
// Market regime classifier: one price bar (high, low, close) in, one result out, in
// order. The front computes the true range against the previous close and drops the
// bar into a two-entry queue; the back updates the SMA, ATR and ATR-baseline rings
// (block RAMs) and classifies. All divisions share one bit-serial divider of
// DW = 62 bits at the default widths, one quotient bit per cycle, used up to four
// times per bar; the divider limits the bar rate, and a result may also wait on
// out_stall. The queue takes new bars while the back works. A configuration write
// restarts the warm-up; no clearing pass follows reset or a write.
module trend_volatility_regime_classifier #(
    parameter int MAX_TREND_WINDOW     = tvr_pkg::DEF_MAX_TREND_WINDOW,
    parameter int MAX_RANGE_WINDOW     = tvr_pkg::DEF_MAX_RANGE_WINDOW,
    parameter int MAX_RANGE_AVG_WINDOW = tvr_pkg::DEF_MAX_RANGE_AVG_WINDOW,
    parameter int PRICE_BITS           = tvr_pkg::DEF_PRICE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tvr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tvr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [tvr_pkg::FIELD_W-1:0]    bar_high,
    input  logic [tvr_pkg::FIELD_W-1:0]    bar_low,
    input  logic [tvr_pkg::FIELD_W-1:0]    bar_close,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tvr_pkg::REGIME_W-1:0]   regime_code,
    output logic [tvr_pkg::BP_OUT_W-1:0]   trend_strength_bp,
    output logic [tvr_pkg::BP_OUT_W-1:0]   volatility_bp,
    output logic [tvr_pkg::CONF_W-1:0]     confidence_pct
);

    localparam int QW = 2 * PRICE_BITS + 1;

    logic          clear;
    logic          q_push, q_pop, q_full, q_not_empty;
    logic [QW-1:0] q_in, q_head;

    assign clear = cfg_write && (cfg_index == tvr_pkg::REG_TREND_WINDOW ||
                                 cfg_index == tvr_pkg::REG_RANGE_WINDOW ||
                                 cfg_index == tvr_pkg::REG_RANGE_AVG_WINDOW);

    tvr_front #(.PRICE_BITS(PRICE_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (clear),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .bar_high  (bar_high),
        .bar_low   (bar_low),
        .bar_close (bar_close),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_in)
    );

    tvr_fifo #(.W(QW), .DEPTH(tvr_pkg::QUEUE_DEPTH)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .not_empty (q_not_empty)
    );

    tvr_core #(
        .MAX_TREND_WINDOW     (MAX_TREND_WINDOW),
        .MAX_RANGE_WINDOW     (MAX_RANGE_WINDOW),
        .MAX_RANGE_AVG_WINDOW (MAX_RANGE_AVG_WINDOW),
        .PRICE_BITS           (PRICE_BITS)
    ) u_core (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .q_not_empty       (q_not_empty),
        .q_data            (q_head),
        .q_pop             (q_pop),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .regime_code       (regime_code),
        .trend_strength_bp (trend_strength_bp),
        .volatility_bp     (volatility_bp),
        .confidence_pct    (confidence_pct)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("queue push while full");

    a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_not_empty)
        else $error("queue pop while empty");

    a_neutral_conf: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((regime_code == tvr_pkg::REGIME_NEUTRAL) ==
                       (confidence_pct == tvr_pkg::CONF_NONE)))
        else $error("confidence disagrees with regime");

    a_neutral_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && regime_code == tvr_pkg::REGIME_NEUTRAL |->
        trend_strength_bp == '0 && volatility_bp == '0)
        else $error("neutral result carries data");

endmodule

// ===== sv/tvr_ram.sv =====
module tvr_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [W-1:0]             wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [W-1:0]             rdata
);

    logic [W-1:0] mem [DEPTH];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tvr_div.sv =====
module tvr_div #(
    parameter int W = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, quo_reg, dvs_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;

    logic [W:0]    shifted, diff;
    logic          ge;
    logic [W-1:0]  rem_next;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        shifted  = {rem_reg, quo_reg[W-1]};
        diff     = shifted - {1'b0, dvs_reg};
        ge       = shifted >= {1'b0, dvs_reg};
        rem_next = ge ? diff[W-1:0] : shifted[W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= !start && (cnt_reg == CW'(1));
            if (start)
            begin
                cnt_reg <= CW'(W);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/tvr_fifo.sv =====
module tvr_fifo #(
    parameter int W     = 65,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] push_data,
    input  logic         pop,
    output logic [W-1:0] head,
    output logic         full,
    output logic         not_empty
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CNW = $clog2(DEPTH + 1);

    logic [W-1:0]   mem_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNW-1:0] count_reg;

    assign full      = count_reg == CNW'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNW'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/tvr_front.sv =====
module tvr_front #(
    parameter int PRICE_BITS = tvr_pkg::DEF_PRICE_BITS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        clear,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [tvr_pkg::FIELD_W-1:0] bar_high,
    input  logic [tvr_pkg::FIELD_W-1:0] bar_low,
    input  logic [tvr_pkg::FIELD_W-1:0] bar_close,
    input  logic                        q_full,
    output logic                        q_push,
    output logic [2*PRICE_BITS:0]       q_data
);

    localparam int PB = PRICE_BITS;

    logic [PB-1:0] prev_close_reg;
    logic          seen_reg;

    logic [PB-1:0] hi, lo, cl, d1, d2, d3, tr;

    // true range against the previous close
    always_comb
    begin
        hi = PB'(bar_high);
        lo = PB'(bar_low);
        cl = PB'(bar_close);
        d1 = (hi >= lo) ? hi - lo : '0;
        d2 = (hi >= prev_close_reg) ? hi - prev_close_reg : prev_close_reg - hi;
        d3 = (lo >= prev_close_reg) ? lo - prev_close_reg : prev_close_reg - lo;
        tr = d1;
        if (d2 > tr)
        begin
            tr = d2;
        end
        if (d3 > tr)
        begin
            tr = d3;
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;
    assign q_data   = {seen_reg, tr, cl};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_close_reg <= '0;
            seen_reg       <= 1'b0;
        end
        else if (clear)
        begin
            prev_close_reg <= '0;
            seen_reg       <= 1'b0;
        end
        else if (q_push)
        begin
            prev_close_reg <= cl;
            seen_reg       <= 1'b1;
        end
    end

endmodule

// ===== sv/tvr_core.sv =====
module tvr_core #(
    parameter int MAX_TREND_WINDOW     = tvr_pkg::DEF_MAX_TREND_WINDOW,
    parameter int MAX_RANGE_WINDOW     = tvr_pkg::DEF_MAX_RANGE_WINDOW,
    parameter int MAX_RANGE_AVG_WINDOW = tvr_pkg::DEF_MAX_RANGE_AVG_WINDOW,
    parameter int PRICE_BITS           = tvr_pkg::DEF_PRICE_BITS
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [tvr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tvr_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           q_not_empty,
    input  logic [2*PRICE_BITS:0]          q_data,
    output logic                           q_pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tvr_pkg::REGIME_W-1:0]   regime_code,
    output logic [tvr_pkg::BP_OUT_W-1:0]   trend_strength_bp,
    output logic [tvr_pkg::BP_OUT_W-1:0]   volatility_bp,
    output logic [tvr_pkg::CONF_W-1:0]     confidence_pct
);

    localparam int PB   = PRICE_BITS;
    localparam int TWW  = $clog2(MAX_TREND_WINDOW + 1);
    localparam int RWW  = $clog2(MAX_RANGE_WINDOW + 1);
    localparam int AWW  = $clog2(MAX_RANGE_AVG_WINDOW + 1);
    localparam int TPW  = $clog2(MAX_TREND_WINDOW);
    localparam int RPW  = $clog2(MAX_RANGE_WINDOW);
    localparam int APW  = $clog2(MAX_RANGE_AVG_WINDOW);
    localparam int CSW  = PB + TWW;
    localparam int RSW  = PB + RWW;
    localparam int ATRW = PB + tvr_pkg::ATR_FRAC;
    localparam int ASW  = ATRW + AWW;
    localparam int CAP  = MAX_TREND_WINDOW + MAX_RANGE_AVG_WINDOW + MAX_RANGE_WINDOW
                          + tvr_pkg::WARMUP_EXTRA;
    localparam int BIW  = $clog2(CAP + 1);
    localparam int TBW  = CSW + tvr_pkg::BP_SCALE_W;
    localparam int VBW  = ATRW + tvr_pkg::BP_SCALE_W;
    localparam int ADW  = RSW + tvr_pkg::ATR_FRAC;
    localparam int DW1  = (TBW > VBW) ? TBW : VBW;
    localparam int DW2  = (ADW > ASW) ? ADW : ASW;
    localparam int DW   = (DW1 > DW2) ? DW1 : DW2;

    typedef enum logic [11:0] {
        ST_IDLE      = 12'b0000_0000_0001,
        ST_RING      = 12'b0000_0000_0010,
        ST_DIV_ATR   = 12'b0000_0000_0100,
        ST_ATR_UPD   = 12'b0000_0000_1000,
        ST_MA        = 12'b0000_0001_0000,
        ST_DIV_MA    = 12'b0000_0010_0000,
        ST_CLS       = 12'b0000_0100_0000,
        ST_TREND     = 12'b0000_1000_0000,
        ST_DIV_TREND = 12'b0001_0000_0000,
        ST_VOL       = 12'b0010_0000_0000,
        ST_DIV_VOL   = 12'b0100_0000_0000,
        ST_OUT       = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic [TWW-1:0] tw_reg;
    logic [RWW-1:0] rw_reg;
    logic [AWW-1:0] aw_reg;
    logic [31:0]    cfg_wide;
    logic           cfg_hit;

    // stream state
    logic [CSW-1:0]  close_sum_reg;
    logic [TWW-1:0]  close_fill_reg;
    logic [TPW-1:0]  close_pos_reg;
    logic [RSW-1:0]  range_sum_reg;
    logic [RWW-1:0]  range_fill_reg;
    logic [RPW-1:0]  range_pos_reg;
    logic [ASW-1:0]  atr_sum_reg;
    logic [AWW-1:0]  atr_count_reg;
    logic [APW-1:0]  atr_pos_reg;
    logic [BIW-1:0]  bar_index_reg;

    // current item
    logic [PB-1:0]   c_reg, tr_reg;
    logic            has_tr_reg, warm_reg, neutral_reg, bull_reg, vol_reg;
    logic [ATRW-1:0] atr_reg, ma_reg;
    logic [CSW-1:0]  cw_reg;
    logic [tvr_pkg::BP_OUT_W-1:0] tbp_reg, vbp_reg;

    // output register
    logic                         out_valid_reg;
    logic [tvr_pkg::REGIME_W-1:0] regime_reg;
    logic [tvr_pkg::BP_OUT_W-1:0] trend_out_reg, vol_out_reg;
    logic [tvr_pkg::CONF_W-1:0]   conf_out_reg;

    // ring memories
    logic [PB-1:0]   close_old, range_old;
    logic [ATRW-1:0] atr_old;
    logic            close_re, range_re, atr_re;
    logic            close_we, range_we, atr_we;

    // ring updates
    logic           close_full, range_full, atr_full;
    logic [CSW-1:0] close_sum_new;
    logic [TWW-1:0] close_fill_new, close_pos_inc;
    logic [TPW-1:0] close_pos_new;
    logic [RSW-1:0] range_sum_new;
    logic [RWW-1:0] range_fill_new, range_pos_inc;
    logic [RPW-1:0] range_pos_new;
    logic [ASW-1:0] atr_sum_new;
    logic [AWW-1:0] atr_count_new, atr_pos_inc;
    logic [APW-1:0] atr_pos_new;
    logic [BIW-1:0] warm_bars;
    logic [TWW-1:0] wmax;

    // trend terms
    logic [CSW-1:0] diff;
    logic           bull_now, vol_now;
    logic [TBW-1:0] tbp_num;
    logic [VBW-1:0] vbp_num;

    // divider
    logic          div_start, div_done;
    logic [DW-1:0] div_a, div_b, div_q;
    logic [tvr_pkg::BP_OUT_W-1:0] q_sat;

    assign q_pop = (state_reg == ST_IDLE) && q_not_empty;

    assign cfg_wide = 32'(cfg_data);
    assign cfg_hit  = cfg_write && (cfg_index == tvr_pkg::REG_TREND_WINDOW ||
                                    cfg_index == tvr_pkg::REG_RANGE_WINDOW ||
                                    cfg_index == tvr_pkg::REG_RANGE_AVG_WINDOW);

    always_comb
    begin
        close_full     = close_fill_reg >= tw_reg;
        close_sum_new  = close_sum_reg - (close_full ? CSW'(close_old) : '0) + CSW'(c_reg);
        close_fill_new = close_full ? close_fill_reg : close_fill_reg + TWW'(1);
        close_pos_inc  = TWW'(close_pos_reg) + TWW'(1);
        close_pos_new  = (close_pos_inc >= tw_reg) ? '0 : TPW'(close_pos_inc);

        range_full     = range_fill_reg >= rw_reg;
        range_sum_new  = range_sum_reg;
        range_fill_new = range_fill_reg;
        range_pos_inc  = RWW'(range_pos_reg) + RWW'(1);
        range_pos_new  = range_pos_reg;
        if (has_tr_reg)
        begin
            range_sum_new  = range_sum_reg - (range_full ? RSW'(range_old) : '0)
                             + RSW'(tr_reg);
            range_fill_new = range_full ? range_fill_reg : range_fill_reg + RWW'(1);
            range_pos_new  = (range_pos_inc >= rw_reg) ? '0 : RPW'(range_pos_inc);
        end

        atr_full      = atr_count_reg >= aw_reg;
        atr_sum_new   = atr_sum_reg - (atr_full ? ASW'(atr_old) : '0) + ASW'(atr_reg);
        atr_count_new = atr_full ? atr_count_reg : atr_count_reg + AWW'(1);
        atr_pos_inc   = AWW'(atr_pos_reg) + AWW'(1);
        atr_pos_new   = (atr_pos_inc >= aw_reg) ? '0 : APW'(atr_pos_inc);

        wmax      = (tw_reg > TWW'(aw_reg)) ? tw_reg : TWW'(aw_reg);
        warm_bars = BIW'(wmax) + BIW'(rw_reg) + BIW'(tvr_pkg::WARMUP_EXTRA);

        bull_now = cw_reg > close_sum_reg;
        diff     = bull_now ? cw_reg - close_sum_reg : close_sum_reg - cw_reg;
        vol_now  = (ma_reg != '0) && (atr_reg > ma_reg);
        tbp_num  = TBW'(diff) * TBW'(tvr_pkg::BP_SCALE);
        vbp_num  = VBW'(atr_reg) * VBW'(tvr_pkg::BP_SCALE);

        q_sat = (div_q > DW'(tvr_pkg::BP_MAX)) ? tvr_pkg::BP_MAX
                                               : tvr_pkg::BP_OUT_W'(div_q);
    end

    // divider operands per step
    always_comb
    begin
        div_start = 1'b0;
        div_a     = '0;
        div_b     = '0;
        case (state_reg)
            ST_RING:
            begin
                div_start = range_fill_new >= rw_reg;
                div_a     = DW'({range_sum_new, {tvr_pkg::ATR_FRAC{1'b0}}});
                div_b     = DW'(rw_reg);
            end
            ST_MA:
            begin
                div_start = atr_count_reg >= aw_reg;
                div_a     = DW'(atr_sum_reg);
                div_b     = DW'(aw_reg);
            end
            ST_TREND:
            begin
                div_start = close_sum_reg != '0;
                div_a     = DW'(tbp_num);
                div_b     = DW'(close_sum_reg);
            end
            ST_VOL:
            begin
                div_start = atr_reg != '0;
                div_a     = DW'(vbp_num);
                div_b     = DW'({c_reg, {tvr_pkg::ATR_FRAC{1'b0}}});
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        close_re   = 1'b0;
        range_re   = 1'b0;
        atr_re     = 1'b0;
        close_we   = 1'b0;
        range_we   = 1'b0;
        atr_we     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    close_re   = 1'b1;
                    range_re   = 1'b1;
                    state_next = ST_RING;
                end
            end
            ST_RING:
            begin
                close_we   = 1'b1;
                range_we   = has_tr_reg;
                state_next = div_start ? ST_DIV_ATR : ST_MA;
            end
            ST_DIV_ATR:
            begin
                if (div_done)
                begin
                    atr_re     = div_q != '0;
                    state_next = (div_q != '0) ? ST_ATR_UPD : ST_MA;
                end
            end
            ST_ATR_UPD:
            begin
                atr_we     = 1'b1;
                state_next = ST_MA;
            end
            ST_MA:
            begin
                state_next = div_start ? ST_DIV_MA : ST_CLS;
            end
            ST_DIV_MA:
            begin
                if (div_done)
                begin
                    state_next = ST_CLS;
                end
            end
            ST_CLS:
            begin
                state_next = (!warm_reg || c_reg == '0) ? ST_OUT : ST_TREND;
            end
            ST_TREND:
            begin
                state_next = div_start ? ST_DIV_TREND : ST_VOL;
            end
            ST_DIV_TREND:
            begin
                if (div_done)
                begin
                    state_next = ST_VOL;
                end
            end
            ST_VOL:
            begin
                state_next = div_start ? ST_DIV_VOL : ST_OUT;
            end
            ST_DIV_VOL:
            begin
                if (div_done)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            tw_reg         <= TWW'(tvr_pkg::RST_TREND_WINDOW);
            rw_reg         <= RWW'(tvr_pkg::RST_RANGE_WINDOW);
            aw_reg         <= AWW'(tvr_pkg::RST_RANGE_AVG_WINDOW);
            close_sum_reg  <= '0;
            close_fill_reg <= '0;
            close_pos_reg  <= '0;
            range_sum_reg  <= '0;
            range_fill_reg <= '0;
            range_pos_reg  <= '0;
            atr_sum_reg    <= '0;
            atr_count_reg  <= '0;
            atr_pos_reg    <= '0;
            bar_index_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (state_reg == ST_OUT && (!out_valid_reg || !out_stall))
            begin
                out_valid_reg <= 1'b1;
            end

            if (cfg_hit)
            begin
                // a register write restarts the stream
                case (cfg_index)
                    tvr_pkg::REG_TREND_WINDOW:
                    begin
                        tw_reg <= (cfg_wide == '0) ? TWW'(1)
                                : (cfg_wide > 32'(MAX_TREND_WINDOW)) ? TWW'(MAX_TREND_WINDOW)
                                : TWW'(cfg_wide);
                    end
                    tvr_pkg::REG_RANGE_WINDOW:
                    begin
                        rw_reg <= (cfg_wide == '0) ? RWW'(1)
                                : (cfg_wide > 32'(MAX_RANGE_WINDOW)) ? RWW'(MAX_RANGE_WINDOW)
                                : RWW'(cfg_wide);
                    end
                    default:
                    begin
                        aw_reg <= (cfg_wide == '0) ? AWW'(1)
                                : (cfg_wide > 32'(MAX_RANGE_AVG_WINDOW))
                                  ? AWW'(MAX_RANGE_AVG_WINDOW)
                                : AWW'(cfg_wide);
                    end
                endcase
                close_sum_reg  <= '0;
                close_fill_reg <= '0;
                close_pos_reg  <= '0;
                range_sum_reg  <= '0;
                range_fill_reg <= '0;
                range_pos_reg  <= '0;
                atr_sum_reg    <= '0;
                atr_count_reg  <= '0;
                atr_pos_reg    <= '0;
                bar_index_reg  <= '0;
            end
            else if (state_reg == ST_RING)
            begin
                close_sum_reg  <= close_sum_new;
                close_fill_reg <= close_fill_new;
                close_pos_reg  <= close_pos_new;
                range_sum_reg  <= range_sum_new;
                range_fill_reg <= range_fill_new;
                range_pos_reg  <= range_pos_new;
                if (bar_index_reg < BIW'(CAP))
                begin
                    bar_index_reg <= bar_index_reg + BIW'(1);
                end
            end
            else if (state_reg == ST_ATR_UPD)
            begin
                atr_sum_reg   <= atr_sum_new;
                atr_count_reg <= atr_count_new;
                atr_pos_reg   <= atr_pos_new;
            end
        end
    end

    // item datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (q_not_empty)
                begin
                    c_reg      <= q_data[PB-1:0];
                    tr_reg     <= q_data[2*PB-1:PB];
                    has_tr_reg <= q_data[2*PB];
                end
            end
            ST_RING:
            begin
                warm_reg <= bar_index_reg >= warm_bars;
                atr_reg  <= '0;
                ma_reg   <= '0;
            end
            ST_DIV_ATR:
            begin
                if (div_done)
                begin
                    atr_reg <= ATRW'(div_q);
                end
            end
            ST_DIV_MA:
            begin
                if (div_done)
                begin
                    ma_reg <= ATRW'(div_q);
                end
            end
            ST_CLS:
            begin
                neutral_reg <= !warm_reg || c_reg == '0;
                cw_reg      <= CSW'(c_reg) * CSW'(tw_reg);
                tbp_reg     <= '0;
                vbp_reg     <= '0;
            end
            ST_TREND:
            begin
                bull_reg <= bull_now;
                vol_reg  <= vol_now;
            end
            ST_DIV_TREND:
            begin
                if (div_done)
                begin
                    tbp_reg <= q_sat;
                end
            end
            ST_DIV_VOL:
            begin
                if (div_done)
                begin
                    vbp_reg <= q_sat;
                end
            end
            ST_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    trend_out_reg <= tbp_reg;
                    vol_out_reg   <= vbp_reg;
                    if (neutral_reg)
                    begin
                        regime_reg   <= tvr_pkg::REGIME_NEUTRAL;
                        conf_out_reg <= tvr_pkg::CONF_NONE;
                    end
                    else
                    begin
                        regime_reg <= bull_reg
                            ? (vol_reg ? tvr_pkg::REGIME_BULL_VOLAT : tvr_pkg::REGIME_BULL_QUIET)
                            : (vol_reg ? tvr_pkg::REGIME_BEAR_VOLAT : tvr_pkg::REGIME_BEAR_QUIET);
                        conf_out_reg <= vol_reg ? tvr_pkg::CONF_VOLATILE : tvr_pkg::CONF_QUIET;
                    end
                end
            end
            default:
            begin
                c_reg <= c_reg;
            end
        endcase
    end

    tvr_ram #(.W(PB), .DEPTH(MAX_TREND_WINDOW)) u_close_ram (
        .clk   (clk),
        .we    (close_we),
        .waddr (close_pos_reg),
        .wdata (c_reg),
        .re    (close_re),
        .raddr (close_pos_reg),
        .rdata (close_old)
    );

    tvr_ram #(.W(PB), .DEPTH(MAX_RANGE_WINDOW)) u_range_ram (
        .clk   (clk),
        .we    (range_we),
        .waddr (range_pos_reg),
        .wdata (tr_reg),
        .re    (range_re),
        .raddr (range_pos_reg),
        .rdata (range_old)
    );

    tvr_ram #(.W(ATRW), .DEPTH(MAX_RANGE_AVG_WINDOW)) u_atr_ram (
        .clk   (clk),
        .we    (atr_we),
        .waddr (atr_pos_reg),
        .wdata (atr_reg),
        .re    (atr_re),
        .raddr (atr_pos_reg),
        .rdata (atr_old)
    );

    tvr_div #(.W(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid         = out_valid_reg;
    assign regime_code       = regime_reg;
    assign trend_strength_bp = trend_out_reg;
    assign volatility_bp     = vol_out_reg;
    assign confidence_pct    = conf_out_reg;

endmodule
